>>> sv/mstx_pkg.sv
// ----------------------------------------------------------------------------
// mstx_pkg
// Shared types and constants for the Manchester stuffed frame transmitter.
// ----------------------------------------------------------------------------
package mstx_pkg;

    // ones-run counter width
    localparam int ONES_W = 3;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // frame delimiter, CRC polynomial, seed after reset
    localparam logic [7:0]  DELIM_BYTE   = 8'h7E;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_SEED_RST = 16'd7439;

    // one frame byte with its framing flags
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_item;

    // sequencer phases of the back end
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_OPEN,
        PH_DATA,
        PH_CRC,
        PH_CLOSE
    } t_phase;

endpackage

>>> sv/mstx_front.sv
// ----------------------------------------------------------------------------
// mstx_front
// Input side: takes frame bytes over valid/ready and holds them in a short
// queue until the symbol sequencer pops them.
// ----------------------------------------------------------------------------
module mstx_front
    import mstx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_frame,
    input  logic       i_last_of_frame,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_item             r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              push, pop;

    assign o_ready   = (r_count != CNT_W'(QDEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = i_pop && o_q_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data: i_data_byte, first: i_first_of_frame,
                                 last: i_last_of_frame};
        end
    end

endmodule

>>> sv/mstx_back.sv
// ----------------------------------------------------------------------------
// mstx_back
// Symbol sequencer: sync, delimiters, stuffed payload, bit-serial CRC-16 and
// the registered line-symbol output with its valid/ready handshake.
// ----------------------------------------------------------------------------
module mstx_back
    import mstx_pkg::*;
#(
    parameter int STUFF_LIMIT = 5,
    parameter int SYNC_PAIRS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_half_first,
    output logic        o_half_second,
    output logic        o_run_last,
    output logic        o_frame_end
);

    localparam int SYNC_SYMS = 2 * SYNC_PAIRS;
    localparam int CNT_MAX   = (SYNC_SYMS > 16) ? SYNC_SYMS : 16;
    localparam int CNT_W     = $clog2(CNT_MAX);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [15:0]        r_sh, n_sh;
    logic [15:0]        r_crc, n_crc;
    logic [15:0]        r_seed;
    logic [ONES_W-1:0]  r_ones, n_ones;
    logic               r_stuff, n_stuff;
    logic               r_tail, n_tail;
    logic [7:0]         r_data, n_data;
    logic               r_last, n_last;

    logic               r_o_valid;
    logic               r_half_first, r_half_second, r_run_last, r_frame_end;

    logic               adv, emit, sym_bit, sym_last, sym_end, load, fin;
    logic               need_stuff, fb;
    logic [ONES_W-1:0]  ones_inc;

    assign adv        = !r_o_valid || i_ready;
    assign ones_inc   = r_ones + 1'b1;
    assign need_stuff = (ones_inc >= ONES_W'(STUFF_LIMIT));
    assign fb         = r_crc[15] ^ r_sh[15];
    assign o_pop      = load;

    // sequencer next state
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_sh     = r_sh;
        n_crc    = r_crc;
        n_ones   = r_ones;
        n_stuff  = r_stuff;
        n_tail   = r_tail;
        n_data   = r_data;
        n_last   = r_last;
        emit     = 1'b0;
        sym_bit  = 1'b0;
        sym_last = 1'b0;
        sym_end  = 1'b0;
        load     = 1'b0;
        fin      = 1'b0;

        if (r_phase == PH_IDLE) begin
            load = i_q_valid;
        end else if (adv) begin
            emit = 1'b1;
            case (r_phase)
                PH_SYNC: begin
                    sym_bit = ~r_cnt[0];
                    if (r_cnt == '0) begin
                        n_phase = PH_OPEN;
                        n_sh    = {DELIM_BYTE, 8'h00};
                        n_cnt   = CNT_W'(7);
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
                PH_OPEN: begin
                    sym_bit = r_sh[15];
                    n_sh    = {r_sh[14:0], 1'b0};
                    if (r_cnt == '0) begin
                        n_phase = PH_DATA;
                        n_sh    = {r_data, 8'h00};
                        n_cnt   = CNT_W'(7);
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
                PH_DATA, PH_CRC: begin
                    if (r_stuff) begin
                        // inserted zero after a full run of ones
                        sym_bit = 1'b0;
                        n_stuff = 1'b0;
                        fin     = r_tail;
                    end else begin
                        sym_bit = r_sh[15];
                        n_sh    = {r_sh[14:0], 1'b0};
                        if (r_phase == PH_DATA) begin
                            n_crc = {r_crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
                        end
                        if (r_sh[15]) begin
                            if (need_stuff) begin
                                n_stuff = 1'b1;
                                n_ones  = '0;
                            end else begin
                                n_ones = ones_inc;
                            end
                        end else begin
                            n_ones = '0;
                        end
                        if (r_cnt == '0) begin
                            if (r_sh[15] && need_stuff) begin
                                n_tail = 1'b1;
                            end else begin
                                fin = 1'b1;
                            end
                        end else begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    if (fin) begin
                        n_tail = 1'b0;
                        if (r_phase == PH_DATA) begin
                            if (r_last) begin
                                n_phase = PH_CRC;
                                n_sh    = n_crc;
                                n_cnt   = CNT_W'(15);
                            end else begin
                                sym_last = 1'b1;
                            end
                        end else begin
                            n_phase = PH_CLOSE;
                            n_sh    = {DELIM_BYTE, 8'h00};
                            n_cnt   = CNT_W'(7);
                        end
                    end
                end
                PH_CLOSE: begin
                    sym_bit = r_sh[15];
                    n_sh    = {r_sh[14:0], 1'b0};
                    if (r_cnt == '0) begin
                        sym_last = 1'b1;
                        sym_end  = 1'b1;
                        n_ones   = '0;
                        n_crc    = r_seed;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
            // item done: chain straight into the next queued byte
            if (sym_last) begin
                load = i_q_valid;
                if (!i_q_valid) begin
                    n_phase = PH_IDLE;
                end
            end
        end

        if (load) begin
            n_data = i_q_item.data;
            n_last = i_q_item.last;
            n_tail = 1'b0;
            if (i_q_item.first) begin
                n_phase = PH_SYNC;
                n_cnt   = CNT_W'(SYNC_SYMS - 1);
                n_ones  = '0;
                n_crc   = r_seed;
            end else begin
                n_phase = PH_DATA;
                n_sh    = {i_q_item.data, 8'h00};
                n_cnt   = CNT_W'(7);
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_crc   <= CRC_SEED_RST;
            r_ones  <= '0;
            r_stuff <= 1'b0;
            r_tail  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_ones  <= n_ones;
            r_stuff <= n_stuff;
            r_tail  <= n_tail;
            r_last  <= n_last;
        end
    end

    // payload holding registers
    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_data <= n_data;
    end

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= CRC_SEED_RST;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // output symbol register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_half_first  <= ~sym_bit;
            r_half_second <= sym_bit;
            r_run_last    <= sym_last;
            r_frame_end   <= sym_end;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_half_first  = r_half_first;
    assign o_half_second = r_half_second;
    assign o_run_last    = r_run_last;
    assign o_frame_end   = r_frame_end;

endmodule

>>> sv/manchester_stuffed_frame_tx_unit.sv
// ----------------------------------------------------------------------------
// manchester_stuffed_frame_tx_unit
// Frame bytes in, Manchester line symbols out, with sync, delimiters, bit
// stuffing and a CRC-16-CCITT trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) transfers one frame byte with its
//   first/last flags. Output channel (o_valid/i_ready) transfers one line
//   symbol per cycle while the receiver is ready; a one is low-high, a zero is high-low.
//   Throughput is set by the symbol sequencer, one symbol per cycle while the
//   receiver is ready: a plain byte takes 8 to 10 symbols, an opening byte
//   adds 2*SYNC_PAIRS + 8, a closing byte adds 16 to 20 for the CRC plus 8
//   for the delimiter. When idle, a byte passes the queue, the sequencer
//   state and the output register before its first symbol. A two-entry
//   queue holds bytes while the sequencer is busy; the source waits only
//   when it is full. A receiver stall holds the output symbol and the sequencer.
//   i_cfg_we writes the CRC seed; it applies at the next frame start or
//   frame end. Reset empties the queue, clears the ones run and sets
//   seed and CRC to 7439.
// ----------------------------------------------------------------------------
module manchester_stuffed_frame_tx_unit
    import mstx_pkg::*;
#(
    parameter int STUFF_LIMIT = 5,
    parameter int SYNC_PAIRS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_frame,
    input  logic        i_last_of_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_half_first,
    output logic        o_half_second,
    output logic        o_run_last,
    output logic        o_frame_end
);

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // byte intake and queue
    mstx_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_last_of_frame  (i_last_of_frame),
        .o_q_valid        (q_valid),
        .o_q_item         (q_item),
        .i_pop            (q_pop)
    );

    // symbol sequencer and output register
    mstx_back #(
        .STUFF_LIMIT (STUFF_LIMIT),
        .SYNC_PAIRS  (SYNC_PAIRS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_half_first  (o_half_first),
        .o_half_second (o_half_second),
        .o_run_last    (o_run_last),
        .o_frame_end   (o_frame_end)
    );

endmodule

>>> sv/mstx_checker.sv
// ----------------------------------------------------------------------------
// mstx_checker
// Port-level checks on the line symbol output of the frame transmitter.
// ----------------------------------------------------------------------------
module mstx_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_half_first,
    input logic o_half_second,
    input logic o_run_last,
    input logic o_frame_end
);

    // every symbol has a mid-bit transition
    a_manchester: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_half_first != o_half_second))
        else $error("symbol without mid-bit transition");

    // frame end closes the byte's symbol run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_run_last)
        else $error("frame end without run last");

    // closing delimiter ends on a zero bit
    a_end_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> (o_half_first && !o_half_second))
        else $error("closing delimiter does not end on zero");

    // stalled symbol is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_half_first)
            && $stable(o_run_last) && $stable(o_frame_end)))
        else $error("stalled symbol changed");

endmodule

bind manchester_stuffed_frame_tx_unit mstx_checker u_mstx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_half_first  (o_half_first),
    .o_half_second (o_half_second),
    .o_run_last    (o_run_last),
    .o_frame_end   (o_frame_end)
);

>>> dv/tb_manchester_stuffed_frame_tx_unit.sv
// ----------------------------------------------------------------------------
// tb_manchester_stuffed_frame_tx_unit
// Self-checking bench for the Manchester stuffed frame transmitter. A clocked
// driver feeds frame bytes from a pending queue, a line-symbol predictor
// builds the expected sync, delimiter, stuffed payload and CRC symbols for
// every byte transfer, and a clocked monitor compares each symbol transfer
// against the oldest expected symbol. Both sides idle at random, and the CRC
// seed is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_manchester_stuffed_frame_tx_unit
    import mstx_pkg::*;
();

    localparam int STUFF_RUN    = 5;
    localparam int SYNC_LEN     = 8;
    localparam int IDLE_PCT     = 27;
    localparam int SETTLE_CYC   = 20;
    localparam int STALL_LIMIT  = 1000;

    // one expected or observed line symbol
    typedef struct packed {
        logic half_first;
        logic half_second;
        logic run_last;
        logic frame_end;
    } t_symbol;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [15:0] i_cfg_wdata      = '0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte      = '0;
    logic        i_first_of_frame = 1'b0;
    logic        i_last_of_frame  = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic        o_half_first;
    logic        o_half_second;
    logic        o_run_last;
    logic        o_frame_end;

    // pending bytes and expected line symbols
    t_item   byte_q[$];
    t_symbol line_q[$];
    t_item   cur_byte;

    // predictor state: seed, running CRC, ones run
    logic [15:0] seed_m  = CRC_SEED_RST;
    logic [15:0] crc_m   = CRC_SEED_RST;
    logic [2:0]  ones_m  = '0;

    logic calm = 1'b0;
    int   n_errors  = 0;
    int   n_bytes   = 0;
    int   n_frames  = 0;
    int   n_symbols = 0;
    int   n_seeds   = 0;
    int   stall_cnt = 0;

    manchester_stuffed_frame_tx_unit #(
        .STUFF_LIMIT (STUFF_RUN),
        .SYNC_PAIRS  (SYNC_LEN)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_last_of_frame  (i_last_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_half_first     (o_half_first),
        .o_half_second    (o_half_second),
        .o_run_last       (o_run_last),
        .o_frame_end      (o_frame_end)
    );

    always #1 i_clk = ~i_clk;

    // one Manchester symbol: one is low-high, zero is high-low
    function automatic void push_symbol(input logic b);
        t_symbol s;
        s.half_first  = ~b;
        s.half_second = b;
        s.run_last    = 1'b0;
        s.frame_end   = 1'b0;
        line_q.push_back(s);
    endfunction

    function automatic void push_raw(input logic [7:0] b);
        for (int i = 7; i >= 0; i--) push_symbol(b[i]);
    endfunction

    // payload or CRC byte, zero inserted after a run of ones
    function automatic void push_stuffed(input logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            push_symbol(b[i]);
            if (b[i]) begin
                ones_m = ones_m + 3'd1;
                if (ones_m >= STUFF_RUN) begin
                    push_symbol(1'b0);
                    ones_m = '0;
                end
            end else begin
                ones_m = '0;
            end
        end
    endfunction

    // CRC-16-CCITT over one byte, MSB first, not reflected
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    // expected symbols for one byte transfer
    function automatic void predict_symbols(input t_item it);
        t_symbol s;
        if (it.first) begin
            for (int i = 0; i < SYNC_LEN; i++) begin
                push_symbol(1'b0);
                push_symbol(1'b1);
            end
            push_raw(DELIM_BYTE);
            ones_m = '0;
            crc_m  = seed_m;
        end
        push_stuffed(it.data);
        crc_m = crc_next(crc_m, it.data);
        if (it.last) begin
            push_stuffed(crc_m[15:8]);
            push_stuffed(crc_m[7:0]);
            push_raw(DELIM_BYTE);
            s = line_q.pop_back();
            s.frame_end = 1'b1;
            line_q.push_back(s);
            ones_m = '0;
            crc_m  = seed_m;
            n_frames++;
        end
        s = line_q.pop_back();
        s.run_last = 1'b1;
        line_q.push_back(s);
    endfunction

    function automatic void check_field(input string name, input logic exp, input logic act);
        if (exp !== act) begin
            $display("%0t: %s expected %0b actual %0b", $time, name, exp, act);
            n_errors++;
        end
    endfunction

    // byte driver: predicts on each transfer, then presents the next byte
    always @(posedge i_clk) begin
        logic done;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            done = i_valid && o_ready;
            if (done) begin
                predict_symbols(cur_byte);
                n_bytes++;
            end
            if (!i_valid || done) begin
                if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_byte         = byte_q.pop_front();
                    i_valid          <= 1'b1;
                    i_data_byte      <= cur_byte.data;
                    i_first_of_frame <= cur_byte.first;
                    i_last_of_frame  <= cur_byte.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // symbol monitor and receiver stalls
    always @(posedge i_clk) begin
        t_symbol got;
        t_symbol want;
        i_ready <= i_rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_half_first, o_half_second, o_run_last, o_frame_end};
            n_symbols++;
            if (line_q.size() == 0) begin
                $display("%0t: symbol with none expected, actual %b", $time, got);
                n_errors++;
            end else begin
                want = line_q.pop_front();
                check_field("half_first",  want.half_first,  got.half_first);
                check_field("half_second", want.half_second, got.half_second);
                check_field("run_last",    want.run_last,    got.run_last);
                check_field("frame_end",   want.frame_end,   got.frame_end);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d symbols still expected",
                     $time, stall_cnt, line_q.size());
            $display("manchester_stuffed_frame_tx_unit: mismatch");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic add_byte(input logic [7:0] d, input logic f, input logic l);
        t_item it;
        it.data  = d;
        it.first = f;
        it.last  = l;
        byte_q.push_back(it);
    endtask

    // bytes weighted toward long runs of ones
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(3))
            0:       b = 8'hFF;
            1:       b = 8'hFF ^ (8'h01 << $urandom_range(7));
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // mostly well-formed frames, some stray bytes with random flags
    task automatic add_random(input int count);
        int len;
        int pushed;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(99) < 15) begin
                add_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                pushed++;
            end else begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++) add_byte(pick_byte(), k == 0, k == len - 1);
                pushed += len;
            end
        end
    endtask

    // wait until every byte is sent and every symbol has arrived
    task automatic settle();
        while (byte_q.size() != 0 || i_valid || line_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        seed_m      = v;
        n_seeds++;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset seed: bytes before any frame opens, then framed bytes
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_byte(8'hA5, 1'b1, 1'b1);
        add_byte(8'h7E, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hF8, 1'b0, 1'b0);
        add_byte(8'h1F, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        settle();

        // zero seed
        write_seed(16'h0000);
        add_byte(8'h00, 1'b1, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h80, 1'b0, 1'b1);
        settle();

        // all-ones seed, a reopened frame
        write_seed(16'hFFFF);
        add_byte(8'hFF, 1'b1, 1'b1);
        add_byte(8'h01, 1'b1, 1'b0);
        add_byte(8'hFE, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b1);
        add_byte(8'h3C, 1'b1, 1'b0);
        add_byte(8'hC3, 1'b1, 1'b1);
        settle();

        // random phases, one of them without idling
        for (int ph = 0; ph < 4; ph++) begin
            write_seed(16'($urandom_range(65535)));
            calm <= (ph == 2);
            add_random(50);
            settle();
        end

        $display("covered %0d bytes in %0d closed frames, %0d line symbols checked",
                 n_bytes, n_frames, n_symbols);
        $display("under %0d seed settings, %0d mismatches", n_seeds + 1, n_errors);
        if (n_errors == 0) begin
            $display("manchester_stuffed_frame_tx_unit: match");
        end else begin
            $display("manchester_stuffed_frame_tx_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
sv/mstx_pkg.sv
sv/mstx_front.sv
sv/mstx_back.sv
sv/manchester_stuffed_frame_tx_unit.sv
sv/mstx_checker.sv
dv/tb_manchester_stuffed_frame_tx_unit.sv
